[hw/rtl/lcsf_pkg.sv]
// ----------------------------------------------------------------------------
// lcsf_pkg: shared types and constants for the LSB coefficient framer
// Register indexes, mode codes, byte geometry and the result flag bundle.
// ----------------------------------------------------------------------------
package lcsf_pkg;

    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = 3;
    localparam int LENGTH_W    = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE         = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMBED_LENGTH = 1'd1;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef struct packed {
        logic bit_carried;
        logic byte_valid;
        logic last_byte;
        logic frame_done;
    } flags_t;

endpackage

[hw/rtl/lcsf_parity.sv]
// ----------------------------------------------------------------------------
// lcsf_parity: coefficient parity forcing
// Forces the LSB of a coefficient to the given bit; a one forced to even
// becomes two so that it never turns into a zero.
// ----------------------------------------------------------------------------
module lcsf_parity #(
    parameter int COEFF_WIDTH = 16
) (
    input  logic [COEFF_WIDTH-1:0] coeff_in,
    input  logic                   force_en,
    input  logic                   force_bit,
    output logic [COEFF_WIDTH-1:0] coeff_out
);

    localparam logic [COEFF_WIDTH-1:0] ONE = COEFF_WIDTH'(1);
    localparam logic [COEFF_WIDTH-1:0] TWO = COEFF_WIDTH'(2);

    always_comb begin
        coeff_out = coeff_in;
        if (force_en) begin
            if (force_bit) begin
                coeff_out = coeff_in | ONE;
            end else if (coeff_in == ONE) begin
                coeff_out = TWO;
            end else begin
                coeff_out = coeff_in & ~ONE;
            end
        end
    end

endmodule

[hw/rtl/lcsf_framer.sv]
// ----------------------------------------------------------------------------
// lcsf_framer: header and payload bit sequencing
// Holds the frame counters, picks the bit each coefficient carries, and
// gathers extracted bytes. State advances once per stepped beat.
// ----------------------------------------------------------------------------
module lcsf_framer #(
    parameter int COEFF_WIDTH = 16,
    parameter int HEADER_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [COEFF_WIDTH-1:0]        coefficient,
    input  logic [lcsf_pkg::BYTE_W-1:0]   message_byte,
    input  logic                          frame_start,
    input  logic                          mode,
    input  logic [lcsf_pkg::LENGTH_W-1:0] embed_length,
    output logic [COEFF_WIDTH-1:0]        coefficient_out,
    output logic [lcsf_pkg::BYTE_W-1:0]   byte_out,
    output lcsf_pkg::flags_t              flags
);

    localparam int HC_W  = $clog2(HEADER_BITS + 1);
    localparam int HDR_W = $clog2(HEADER_BITS);
    localparam int BW    = lcsf_pkg::BYTE_W;
    localparam int BIW   = lcsf_pkg::BIT_IDX_W;
    localparam int LW    = lcsf_pkg::LENGTH_W;

    logic [HC_W-1:0]        header_count_reg, header_count_next, hc_cur;
    logic [BIW-1:0]         bit_index_reg, bit_index_next, bi_cur;
    logic [LW-1:0]          byte_count_reg, byte_count_next, bc_cur;
    logic [BW-1:0]          held_byte_reg, held_byte_next, hb_cur;
    logic [HEADER_BITS-1:0] read_length_reg, read_length_next, rl_cur;
    logic                   done_flag_reg, done_flag_next, done_cur;

    logic                   extract;
    logic [HEADER_BITS-1:0] header_word;
    logic [HDR_W-1:0]       header_sel;
    logic [BW-1:0]          embed_byte;
    logic                   carried_bit;
    logic                   force_en;

    assign extract     = (mode == lcsf_pkg::MODE_EXTRACT);
    assign header_word = embed_length[HEADER_BITS-1:0];

    // frame_start clears the counters, held byte, read length and done flag ahead of this coefficient
    assign hc_cur   = frame_start ? '0 : header_count_reg;
    assign bi_cur   = frame_start ? '0 : bit_index_reg;
    assign bc_cur   = frame_start ? '0 : byte_count_reg;
    assign hb_cur   = frame_start ? '0 : held_byte_reg;
    assign rl_cur   = frame_start ? '0 : read_length_reg;
    assign done_cur = frame_start ? 1'b0 : done_flag_reg;

    assign header_sel = HDR_W'(HEADER_BITS - 1) - hc_cur[HDR_W-1:0];
    assign embed_byte = (bi_cur == '0) ? message_byte : hb_cur;

    always_comb begin
        header_count_next = hc_cur;
        bit_index_next    = bi_cur;
        byte_count_next   = bc_cur;
        held_byte_next    = hb_cur;
        read_length_next  = rl_cur;
        done_flag_next    = done_cur;
        carried_bit       = 1'b0;
        force_en          = 1'b0;
        flags             = '0;
        byte_out          = '0;
        if (!done_cur) begin
            flags.bit_carried = 1'b1;
            force_en          = !extract;
            if (hc_cur < HC_W'(HEADER_BITS)) begin
                carried_bit       = extract ? coefficient[0] : header_word[header_sel];
                read_length_next  = {rl_cur[HEADER_BITS-2:0], carried_bit};
                header_count_next = hc_cur + HC_W'(1);
                if (hc_cur == HC_W'(HEADER_BITS - 1) && read_length_next == '0) begin
                    done_flag_next = 1'b1;
                end
            end else begin
                if (extract) begin
                    held_byte_next = {hb_cur[BW-2:0], coefficient[0]};
                end else begin
                    held_byte_next = embed_byte;
                    carried_bit    = embed_byte[lcsf_pkg::LAST_BIT - bi_cur];
                end
                if (bi_cur == lcsf_pkg::LAST_BIT) begin
                    bit_index_next  = '0;
                    byte_count_next = bc_cur + LW'(1);
                    if (byte_count_next >= LW'(rl_cur)) begin
                        done_flag_next = 1'b1;
                    end
                    if (extract) begin
                        flags.byte_valid = 1'b1;
                        flags.last_byte  = done_flag_next;
                        byte_out         = held_byte_next;
                    end
                end else begin
                    bit_index_next = bi_cur + BIW'(1);
                end
            end
        end
        flags.frame_done = done_flag_next;
    end

    lcsf_parity #(
        .COEFF_WIDTH(COEFF_WIDTH)
    ) u_parity (
        .coeff_in (coefficient),
        .force_en (force_en),
        .force_bit(carried_bit),
        .coeff_out(coefficient_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg <= '0;
            bit_index_reg    <= '0;
            byte_count_reg   <= '0;
            held_byte_reg    <= '0;
            read_length_reg  <= '0;
            done_flag_reg    <= 1'b0;
        end else if (step_en) begin
            header_count_reg <= header_count_next;
            bit_index_reg    <= bit_index_next;
            byte_count_reg   <= byte_count_next;
            held_byte_reg    <= held_byte_next;
            read_length_reg  <= read_length_next;
            done_flag_reg    <= done_flag_next;
        end
    end

endmodule

[hw/rtl/lsb_coefficient_stego_framer.sv]
// ----------------------------------------------------------------------------
// Pipeline: each input beat passes the input register, then the result
//   register, on its way to the result beat.
// Throughput: one coefficient per cycle unless m_ready stalls the result; the
//   framer step between the two registers is combinational.
// Reset: synchronous active-low aresetn clears both valids, the frame
//   counters and the mode and length registers.
// ----------------------------------------------------------------------------
// lsb_coefficient_stego_framer: LSB parity stego embed/extract on coefficients
// Embeds or extracts a length header and message bytes through the parity
// of a coefficient stream.
// ----------------------------------------------------------------------------
module lsb_coefficient_stego_framer #(
    parameter int COEFF_WIDTH = 16,
    parameter int HEADER_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lcsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcsf_pkg::LENGTH_W-1:0]    cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [COEFF_WIDTH-1:0]    s_coefficient,
    input  logic [lcsf_pkg::BYTE_W-1:0]      s_message_byte,
    input  logic                             s_frame_start,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [COEFF_WIDTH-1:0]    m_coefficient_out,
    output logic                             m_bit_carried,
    output logic [lcsf_pkg::BYTE_W-1:0]      m_byte_out,
    output logic                             m_byte_valid,
    output logic                             m_last_byte,
    output logic                             m_frame_done
);

    logic                          mode_reg;
    logic [lcsf_pkg::LENGTH_W-1:0] embed_length_reg;

    logic                          in_valid_reg;
    logic [COEFF_WIDTH-1:0]        in_coeff_reg;
    logic [lcsf_pkg::BYTE_W-1:0]   in_msg_reg;
    logic                          in_start_reg;

    logic                          out_valid_reg;
    logic [COEFF_WIDTH-1:0]        out_coeff_reg;
    logic [lcsf_pkg::BYTE_W-1:0]   out_byte_reg;
    lcsf_pkg::flags_t              out_flags_reg;

    logic                          advance;
    logic                          step_en;
    logic [COEFF_WIDTH-1:0]        coeff_next;
    logic [lcsf_pkg::BYTE_W-1:0]   byte_next;
    lcsf_pkg::flags_t              flags_next;

    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= lcsf_pkg::MODE_EMBED;
            embed_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lcsf_pkg::CFG_MODE:         mode_reg         <= cfg_wr_data[0];
                lcsf_pkg::CFG_EMBED_LENGTH: embed_length_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_coeff_reg <= s_coefficient;
            in_msg_reg   <= s_message_byte;
            in_start_reg <= s_frame_start;
        end
    end

    lcsf_framer #(
        .COEFF_WIDTH(COEFF_WIDTH),
        .HEADER_BITS(HEADER_BITS)
    ) u_framer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .coefficient    (in_coeff_reg),
        .message_byte   (in_msg_reg),
        .frame_start    (in_start_reg),
        .mode           (mode_reg),
        .embed_length   (embed_length_reg),
        .coefficient_out(coeff_next),
        .byte_out       (byte_next),
        .flags          (flags_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_coeff_reg <= coeff_next;
            out_byte_reg  <= byte_next;
            out_flags_reg <= flags_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_coefficient_out = out_coeff_reg;
    assign m_byte_out        = out_byte_reg;
    assign m_bit_carried     = out_flags_reg.bit_carried;
    assign m_byte_valid      = out_flags_reg.byte_valid;
    assign m_last_byte       = out_flags_reg.last_byte;
    assign m_frame_done      = out_flags_reg.frame_done;

endmodule

[hw/rtl/lcsf_checker.sv]
// ----------------------------------------------------------------------------
// lcsf_checker: port-level checks for the LSB coefficient framer
// Result flag consistency and result beat hold under back-pressure.
// ----------------------------------------------------------------------------
module lcsf_checker #(
    parameter int COEFF_WIDTH = 16
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [COEFF_WIDTH-1:0]      m_coefficient_out,
    input logic                        m_bit_carried,
    input logic [lcsf_pkg::BYTE_W-1:0] m_byte_out,
    input logic                        m_byte_valid,
    input logic                        m_last_byte,
    input logic                        m_frame_done
);

    a_byte_needs_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_bit_carried)
        else $error("byte completed on a coefficient that carried no bit");

    a_last_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> m_byte_valid && m_frame_done)
        else $error("last byte flagged without a valid byte or a done frame");

    a_idle_byte_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_byte_out == '0 && !m_last_byte)
        else $error("byte fields set on a beat with no byte");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coefficient_out)
            && $stable(m_byte_out) && $stable(m_frame_done) && $stable(m_bit_carried))
        else $error("result beat changed while stalled");

endmodule

bind lsb_coefficient_stego_framer lcsf_checker #(
    .COEFF_WIDTH(COEFF_WIDTH)
) u_lcsf_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_coefficient_out(m_coefficient_out),
    .m_bit_carried    (m_bit_carried),
    .m_byte_out       (m_byte_out),
    .m_byte_valid     (m_byte_valid),
    .m_last_byte      (m_last_byte),
    .m_frame_done     (m_frame_done)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for lsb_coefficient_stego_framer
// Streams coefficient frames in embed and extract mode, both well-formed and
// broken, with random gaps on the input and back-pressure on the output. A behavioural
// framer in the bench predicts every result beat, which is compared field by
// field. Registers are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb;

    localparam int COEFF_W   = 16;
    localparam int HDR_BITS  = 32;
    localparam int N_ITEMS   = 1570;
    localparam int LIMIT     = 400000;

    typedef struct {
        logic [COEFF_W-1:0]          coeff;
        logic [lcsf_pkg::BYTE_W-1:0] msg;
        logic                        start;
    } coeff_beat_t;

    typedef struct {
        logic [COEFF_W-1:0]          coeff;
        logic [lcsf_pkg::BYTE_W-1:0] byte_out;
        lcsf_pkg::flags_t            flags;
    } framed_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [lcsf_pkg::CFG_INDEX_W-1:0] cfg_index = lcsf_pkg::CFG_MODE;
    logic [lcsf_pkg::LENGTH_W-1:0]    cfg_wr_data = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [COEFF_W-1:0]        s_coefficient = '0;
    logic [lcsf_pkg::BYTE_W-1:0]      s_message_byte = '0;
    logic                             s_frame_start = 1'b0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [COEFF_W-1:0]        m_coefficient_out;
    logic                             m_bit_carried;
    logic [lcsf_pkg::BYTE_W-1:0]      m_byte_out;
    logic                             m_byte_valid;
    logic                             m_last_byte;
    logic                             m_frame_done;

    lsb_coefficient_stego_framer #(
        .COEFF_WIDTH (COEFF_W),
        .HEADER_BITS (HDR_BITS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_coefficient     (s_coefficient),
        .s_message_byte    (s_message_byte),
        .s_frame_start     (s_frame_start),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_coefficient_out (m_coefficient_out),
        .m_bit_carried     (m_bit_carried),
        .m_byte_out        (m_byte_out),
        .m_byte_valid      (m_byte_valid),
        .m_last_byte       (m_last_byte),
        .m_frame_done      (m_frame_done)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    coeff_beat_t coeffs_to_send[$];
    framed_t     stego_results_due[$];

    int  cycle = 0;
    int  mismatches = 0;
    int  sent = 0;
    int  results_seen = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  steady;

    // shadow registers and frame counters
    logic                           sh_mode = lcsf_pkg::MODE_EMBED;
    logic [lcsf_pkg::LENGTH_W-1:0]  sh_length = '0;
    int                             hdr_cnt = 0;
    logic [lcsf_pkg::BIT_IDX_W-1:0] bit_pos = '0;
    logic [lcsf_pkg::LENGTH_W-1:0]  bytes_done = '0;
    logic [lcsf_pkg::BYTE_W-1:0]    gather = '0;
    logic [lcsf_pkg::LENGTH_W-1:0]  length_seen = '0;
    logic                           done = 1'b0;

    assign steady = (cycle >= 500) && (cycle < 1400);

    function automatic logic [COEFF_W-1:0] forced(logic [COEFF_W-1:0] c, logic b);
        if (!b) begin
            if (c == COEFF_W'(1))
                return COEFF_W'(2);
            if (c[0])
                return c - 1'b1;
            return c;
        end
        if (!c[0])
            return c + 1'b1;
        return c;
    endfunction

    task automatic parity_framer_step(input coeff_beat_t b, output framed_t r);
        logic bitv;
        r.coeff = b.coeff;
        r.byte_out = '0;
        r.flags = '0;
        if (b.start) begin
            hdr_cnt = 0;
            bit_pos = '0;
            bytes_done = '0;
            gather = '0;
            length_seen = '0;
            done = 1'b0;
        end
        if (!done) begin
            r.flags.bit_carried = 1'b1;
            if (hdr_cnt < HDR_BITS) begin
                if (sh_mode == lcsf_pkg::MODE_EXTRACT) begin
                    bitv = b.coeff[0];
                end else begin
                    bitv = sh_length[HDR_BITS-1-hdr_cnt];
                    r.coeff = forced(b.coeff, bitv);
                end
                length_seen = {length_seen[lcsf_pkg::LENGTH_W-2:0], bitv};
                hdr_cnt++;
                if (hdr_cnt == HDR_BITS && length_seen == '0)
                    done = 1'b1;
            end else begin
                if (sh_mode == lcsf_pkg::MODE_EXTRACT) begin
                    gather = {gather[lcsf_pkg::BYTE_W-2:0], b.coeff[0]};
                end else begin
                    if (bit_pos == '0)
                        gather = b.msg;
                    r.coeff = forced(b.coeff, gather[lcsf_pkg::LAST_BIT-bit_pos]);
                end
                if (bit_pos == lcsf_pkg::LAST_BIT) begin
                    bit_pos = '0;
                    bytes_done++;
                    if (bytes_done >= length_seen)
                        done = 1'b1;
                    if (sh_mode == lcsf_pkg::MODE_EXTRACT) begin
                        r.flags.byte_valid = 1'b1;
                        r.byte_out = gather;
                        r.flags.last_byte = done;
                    end
                end else begin
                    bit_pos++;
                end
            end
        end
        r.flags.frame_done = done;
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeff();
        logic [COEFF_W-1:0] edges[10] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff,
                                          16'h0002, 16'hfffe, 16'h0003, 16'h7ffe, 16'h8001};
        if ($urandom_range(0, 5) == 0)
            return edges[$urandom_range(0, 9)];
        return COEFF_W'($urandom);
    endfunction

    function automatic logic [lcsf_pkg::LENGTH_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return lcsf_pkg::LENGTH_W'($urandom_range(0, 3));
        if (r < 8)
            return lcsf_pkg::LENGTH_W'($urandom_range(4, 6));
        if (r == 8)
            return '1;
        return lcsf_pkg::LENGTH_W'($urandom);
    endfunction

    task automatic write_reg(input logic [lcsf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lcsf_pkg::LENGTH_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == lcsf_pkg::CFG_MODE)
            sh_mode = val[0];
        else
            sh_length = val;
    endtask

    task automatic wait_drained();
        do
            @(posedge aclk);
        while (coeffs_to_send.size() != 0 || stego_results_due.size() != 0 || s_valid);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_plain(input int n, input bit first_start);
        coeff_beat_t it;
        for (int i = 0; i < n; i++) begin
            it.coeff = pick_coeff();
            it.msg = lcsf_pkg::BYTE_W'($urandom);
            it.start = first_start && i == 0;
            coeffs_to_send.push_back(it);
        end
        sent += n;
    endtask

    // one frame: header, payload, a short tail; sometimes cut short
    task automatic push_frame(input bit ext, input logic [lcsf_pkg::LENGTH_W-1:0] len,
                              input bit with_start);
        coeff_beat_t it;
        int n_bytes;
        int total;
        n_bytes = (len <= 6) ? int'(len) : $urandom_range(0, 3);
        total = HDR_BITS + 8 * n_bytes + $urandom_range(0, 4);
        if ($urandom_range(0, 4) == 0)
            total = $urandom_range(1, total);
        for (int i = 0; i < total; i++) begin
            it.coeff = pick_coeff();
            it.msg = lcsf_pkg::BYTE_W'($urandom);
            it.start = (with_start && i == 0) || $urandom_range(0, 59) == 0;
            if (ext)
                it.coeff[0] = (i < HDR_BITS) ? len[HDR_BITS-1-i] : 1'($urandom);
            coeffs_to_send.push_back(it);
        end
        sent += total;
    endtask

    always @(posedge aclk) begin : drive
        coeff_beat_t nxt;
        coeff_beat_t cur;
        framed_t     want;
        logic        offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                cur.coeff = s_coefficient;
                cur.msg = s_message_byte;
                cur.start = s_frame_start;
                parity_framer_step(cur, want);
                stego_results_due.push_back(want);
                offer = 1'b0;
            end
            if (!offer) begin
                if (coeffs_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 22)) begin
                    nxt = coeffs_to_send.pop_front();
                    s_coefficient <= nxt.coeff;
                    s_message_byte <= nxt.msg;
                    s_frame_start <= nxt.start;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : observe
        framed_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (stego_results_due.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    mismatches++;
                end else begin
                    want = stego_results_due.pop_front();
                    check_field("coefficient_out", want.coeff, $unsigned(m_coefficient_out));
                    check_field("bit_carried", want.flags.bit_carried, m_bit_carried);
                    check_field("byte_out", want.byte_out, m_byte_out);
                    check_field("byte_valid", want.flags.byte_valid, m_byte_valid);
                    check_field("last_byte", want.flags.last_byte, m_last_byte);
                    check_field("frame_done", want.flags.frame_done, m_frame_done);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 600 && coeffs_to_send.size() > 8) begin
                // long stall so the block backs up into its input
                hold_done = 1'b1;
                hold_left = 250;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || $urandom_range(0, 99) >= 22;
            end
        end
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT) begin
            $display("lsb_coefficient_stego_framer test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic                          mode;
        logic [lcsf_pkg::LENGTH_W-1:0] len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults, no frame start: zero bits forced onto random and edge coefficients
        push_plain(10, 1'b0);
        wait_drained();
        // length changed mid-header: ones from here on
        write_reg(lcsf_pkg::CFG_EMBED_LENGTH, '1);
        push_plain(10, 1'b0);
        wait_drained();

        while (sent < N_ITEMS) begin
            mode = 1'($urandom_range(0, 1));
            len = pick_length();
            write_reg(lcsf_pkg::CFG_MODE, lcsf_pkg::LENGTH_W'(mode));
            write_reg(lcsf_pkg::CFG_EMBED_LENGTH, len);
            if (mode == lcsf_pkg::MODE_EXTRACT)
                len = pick_length();
            repeat ($urandom_range(1, 3))
                push_frame(mode == lcsf_pkg::MODE_EXTRACT, len, $urandom_range(0, 4) != 0);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("lsb_coefficient_stego_framer test passed");
        else
            $display("lsb_coefficient_stego_framer test failed");
        $finish;
    end

endmodule
